// ----- rtl/tdht_pkg.sv -----
// ============================================================================
// tdht_pkg
// Shared types, constants and hash helper for the tile damage hash tracker.
// ============================================================================
package tdht_pkg;

    // Default grid geometry
    localparam int GRID_TILES_DEF = 32;
    localparam int TILE_SHIFT_DEF = 7;

    // Field widths
    localparam int HASH_W  = 32;
    localparam int COORD_W = 12;
    localparam int TILE_W  = 5;
    localparam int REQ_W   = 2;

    // Stream word widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 8;

    // Output word bit positions
    localparam int OUT_DIRTY_BIT = 0;
    localparam int OUT_CLIP_BIT  = 1;

    localparam logic [HASH_W-1:0] HASH_MUL        = 32'd31;
    localparam logic [HASH_W-1:0] HASH_PREV_RESET = 32'hFFFF_FFFF;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_FRAME  = 2'd0,
        REQ_DAMAGE = 2'd1,
        REQ_CHECK  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // One step of the rolling hash: a * 31 + b, modulo 2^32
    function automatic logic [HASH_W-1:0] mul31_add(input logic [HASH_W-1:0] a,
                                                    input logic [HASH_W-1:0] b);
        return a * HASH_MUL + b;
    endfunction

endpackage

// ----- rtl/tdht_ram.sv -----
// ============================================================================
// tdht_ram
// Generic single-port RAM with registered read data.
// ============================================================================
module tdht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/tile_damage_hash_tracker_core.sv -----
// ============================================================================
// tile_damage_hash_tracker_core
// Per-tile damage hashes for a square tile grid, held in two RAMs.
// ============================================================================
// One word in, one word out. After reset the block fills every entry of both
// hash RAMs (current to zero, previous to all ones) and holds s_tready low
// meanwhile. Each accepted word is worked on alone, and every kind ends in a
// finish state that loads the result register once it is free. A check goes
// through a read state and a compare state before that load; a check of a
// tile outside the grid goes straight to it. A begin-frame clear sweeps every
// entry of the current-hash RAM before the load. A damage rectangle goes
// through the hash steps and a range setup, then a read state and a write
// state for each covered tile before the load, since every tile is a
// read-modify-write through the single RAM port. An unused code goes straight
// to the load. s_tready returns high once the result has entered the output
// register; one result may wait there while the next word is taken.
module tile_damage_hash_tracker_core
    import tdht_pkg::*;
#(
    parameter int GRID_TILES = tdht_pkg::GRID_TILES_DEF,
    parameter int TILE_SHIFT = tdht_pkg::TILE_SHIFT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // tuser: req_type[1:0]
    input  logic [tdht_pkg::REQ_W-1:0]    s_tuser,
    // tdata: rect_x[11:0], rect_y[23:12], rect_w[35:24], rect_h[47:36],
    //        tile_col[52:48], tile_row[57:53], zero[63:58]
    input  logic [tdht_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: is_dirty[0], clipped[1], zero[7:2]
    output logic [tdht_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    localparam int TILE_COUNT = GRID_TILES * GRID_TILES;
    localparam int AW         = $clog2(TILE_COUNT);
    localparam int CW         = $clog2(GRID_TILES + 1);
    localparam int TILE_SIZE  = 1 << TILE_SHIFT;
    localparam int SUM_W      = ((TILE_SHIFT > COORD_W) ? TILE_SHIFT : COORD_W + 1) + 1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_SETUP,
        ST_RD,
        ST_WR,
        ST_CLEAR,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [COORD_W-1:0]    x_reg, x_next, y_reg, y_next;
    logic [COORD_W-1:0]    w_reg, w_next, h_reg, h_next;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [1:0]            step_reg, step_next;
    logic [CW-1:0]         c0_reg, c0_next, c1_reg, c1_next, r1_reg, r1_next;
    logic [CW-1:0]         col_reg, col_next, row_reg, row_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [AW-1:0]         chk_addr_reg, chk_addr_next;
    logic                  dirty_reg, dirty_next, clip_reg, clip_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic [AW-1:0]         ram_addr;
    logic                  cur_we, prev_we;
    logic [HASH_W-1:0]     cur_wdata, prev_wdata;
    logic [HASH_W-1:0]     cur_rdata, prev_rdata;

    // Input word fields
    logic [COORD_W-1:0]    in_x, in_y, in_w, in_h;
    logic [TILE_W-1:0]     in_col, in_row;
    logic                  s_fire;

    assign in_x   = s_tdata[11:0];
    assign in_y   = s_tdata[23:12];
    assign in_w   = s_tdata[35:24];
    assign in_h   = s_tdata[47:36];
    assign in_col = s_tdata[52:48];
    assign in_row = s_tdata[57:53];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Span arithmetic for the damage rectangle
    logic [SUM_W-1:0]      col_end_w, row_end_w;
    logic [SUM_W-1:0]      col_beg_w, row_beg_w;
    logic                  col_cut, row_cut;
    logic [CW-1:0]         col_end, row_end;
    logic                  span_empty;

    always_comb
    begin
        col_beg_w  = SUM_W'(x_reg >> TILE_SHIFT);
        row_beg_w  = SUM_W'(y_reg >> TILE_SHIFT);
        col_end_w  = SUM_W'((SUM_W'(x_reg) + SUM_W'(w_reg) + SUM_W'(TILE_SIZE - 1))
                            >> TILE_SHIFT);
        row_end_w  = SUM_W'((SUM_W'(y_reg) + SUM_W'(h_reg) + SUM_W'(TILE_SIZE - 1))
                            >> TILE_SHIFT);
        col_cut    = col_end_w > SUM_W'(GRID_TILES);
        row_cut    = row_end_w > SUM_W'(GRID_TILES);
        col_end    = col_cut ? CW'(GRID_TILES) : CW'(col_end_w);
        row_end    = row_cut ? CW'(GRID_TILES) : CW'(row_end_w);
        // start outside the grid, or a zero-size span on a tile boundary
        span_empty = (col_beg_w >= SUM_W'(col_end)) || (row_beg_w >= SUM_W'(row_end));
    end

    // Hash operand for the current step
    logic [COORD_W-1:0]    hash_op;

    always_comb
    begin
        case (step_reg)
            2'd0:    hash_op = y_reg;
            2'd1:    hash_op = w_reg;
            default: hash_op = h_reg;
        endcase
    end

    // RAM port control
    always_comb
    begin
        ram_addr   = cnt_reg;
        cur_we     = 1'b0;
        prev_we    = 1'b0;
        cur_wdata  = '0;
        prev_wdata = HASH_PREV_RESET;
        case (state_reg)
            ST_INIT:
            begin
                cur_we  = 1'b1;
                prev_we = 1'b1;
            end
            ST_CLEAR:
            begin
                cur_we = 1'b1;
            end
            ST_RD:
            begin
                ram_addr = AW'(base_reg + AW'(col_reg));
            end
            ST_WR:
            begin
                ram_addr  = AW'(base_reg + AW'(col_reg));
                cur_we    = 1'b1;
                cur_wdata = mul31_add(cur_rdata, hash_reg);
            end
            ST_CHK_RD:
            begin
                ram_addr = chk_addr_reg;
            end
            ST_CHK_CMP:
            begin
                ram_addr   = chk_addr_reg;
                prev_we    = 1'b1;
                prev_wdata = cur_rdata;
            end
            default:
            begin
                ram_addr = cnt_reg;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        hash_next     = hash_reg;
        step_next     = step_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        r1_next       = r1_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        base_next     = base_reg;
        chk_addr_next = chk_addr_reg;
        dirty_next    = dirty_reg;
        clip_next     = clip_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        case (state_reg)
            ST_INIT:
            begin
                cnt_next = AW'(cnt_reg + 1'b1);
                if (32'(cnt_reg) == TILE_COUNT - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    x_next     = in_x;
                    y_next     = in_y;
                    w_next     = in_w;
                    h_next     = in_h;
                    hash_next  = HASH_W'(in_x);
                    step_next  = 2'd0;
                    cnt_next   = '0;
                    dirty_next = 1'b0;
                    clip_next  = 1'b0;
                    chk_addr_next = AW'(32'(in_row) * GRID_TILES + 32'(in_col));
                    case (s_tuser)
                        REQ_FRAME:
                        begin
                            state_next = ST_CLEAR;
                        end
                        REQ_DAMAGE:
                        begin
                            state_next = ST_HASH;
                        end
                        REQ_CHECK:
                        begin
                            if ((32'(in_col) < GRID_TILES) && (32'(in_row) < GRID_TILES))
                            begin
                                state_next = ST_CHK_RD;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                hash_next = mul31_add(hash_reg, HASH_W'(hash_op));
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                clip_next = col_cut || row_cut;
                c0_next   = CW'(col_beg_w);
                c1_next   = col_end;
                r1_next   = row_end;
                col_next  = CW'(col_beg_w);
                row_next  = CW'(row_beg_w);
                base_next = AW'(32'(CW'(row_beg_w)) * GRID_TILES);
                state_next = span_empty ? ST_FINISH : ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                state_next = ST_RD;
                if (CW'(col_reg + 1'b1) < c1_reg)
                begin
                    col_next = CW'(col_reg + 1'b1);
                end
                else if (CW'(row_reg + 1'b1) < r1_reg)
                begin
                    col_next  = c0_reg;
                    row_next  = CW'(row_reg + 1'b1);
                    base_next = AW'(base_reg + AW'(GRID_TILES));
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CLEAR:
            begin
                cnt_next = AW'(cnt_reg + 1'b1);
                if (32'(cnt_reg) == TILE_COUNT - 1)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CHK_RD:
            begin
                state_next = ST_CHK_CMP;
            end
            ST_CHK_CMP:
            begin
                dirty_next = (cur_rdata != prev_rdata);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // load the result once the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[OUT_DIRTY_BIT] = dirty_reg;
                    m_data_next[OUT_CLIP_BIT]  = clip_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            step_reg     <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            dirty_reg    <= 1'b0;
            clip_reg     <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            w_reg        <= '0;
            h_reg        <= '0;
            hash_reg     <= '0;
            c0_reg       <= '0;
            c1_reg       <= '0;
            r1_reg       <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            base_reg     <= '0;
            chk_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            step_reg     <= step_next;
            m_valid_reg  <= m_valid_next;
            m_data_reg   <= m_data_next;
            dirty_reg    <= dirty_next;
            clip_reg     <= clip_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            hash_reg     <= hash_next;
            c0_reg       <= c0_next;
            c1_reg       <= c1_next;
            r1_reg       <= r1_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            base_reg     <= base_next;
            chk_addr_reg <= chk_addr_next;
        end
    end

    // Current tile hashes
    tdht_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TILE_COUNT)
    ) u_cur_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (cur_we),
        .wdata (cur_wdata),
        .rdata (cur_rdata)
    );

    // Hashes seen at the last check
    tdht_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TILE_COUNT)
    ) u_prev_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (prev_we),
        .wdata (prev_wdata),
        .rdata (prev_rdata)
    );

endmodule

// ----- rtl/tdht_checker.sv -----
// ============================================================================
// tdht_checker
// Port-level checks for the tile damage hash tracker, bound to the top level.
// ============================================================================
module tdht_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [tdht_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import tdht_pkg::*;

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

    // One word in flight: the block is busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while previous word still in work");

    // A result is never both dirty and clipped
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OUT_DIRTY_BIT] && m_tdata[OUT_CLIP_BIT]))
    else $error("result flags dirty and clipped together");

    // Pad bits of the result stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_DATA_W-1:2] == '0))
    else $error("result pad bits not zero");

endmodule

bind tile_damage_hash_tracker_core tdht_checker u_tdht_checker (.*);

// ----- tb/tdht_result_checker.sv -----
// ============================================================================
// tdht_result_checker
// Watches both stream channels of the tile damage hash tracker, keeps its own
// copy of the current and previous tile hashes, predicts one result word per
// accepted input word and compares every result word against the oldest
// prediction still waiting.
// ============================================================================
module tdht_result_checker
    import tdht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [REQ_W-1:0]    s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    output int                  mismatches,
    output int                  pending,
    output int                  results_seen,
    output int                  dirty_seen,
    output int                  clipped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID      = GRID_TILES_DEF;
    localparam int SHIFT     = TILE_SHIFT_DEF;
    localparam int NUM_TILES = GRID * GRID;
    localparam int TILE_PIX  = 1 << SHIFT;

    typedef struct packed {
        logic is_dirty;
        logic clipped;
    } tile_result_t;

    logic [HASH_W-1:0] cur_hash  [NUM_TILES];
    logic [HASH_W-1:0] prev_hash [NUM_TILES];
    tile_result_t      result_fifo [$];
    tile_result_t      want;

    int err_count;
    int seen_count;
    int dirty_count;
    int clip_count;

    assign mismatches   = err_count;
    assign pending      = result_fifo.size();
    assign results_seen = seen_count;
    assign dirty_seen   = dirty_count;
    assign clipped_seen = clip_count;

    // Tile hash tables after reset
    function automatic void clear_tiles();
        int i;
        for (i = 0; i < NUM_TILES; i++)
        begin
            cur_hash[i]  = '0;
            prev_hash[i] = HASH_PREV_RESET;
        end
    endfunction

    // Exclusive end of a covered tile span, cut to the grid
    function automatic int span_stop(input logic [COORD_W-1:0] start,
                                     input logic [COORD_W-1:0] len,
                                     inout logic cut);
        int stop;
        stop = (int'(start) + int'(len) + TILE_PIX - 1) >> SHIFT;
        if (stop > GRID)
        begin
            stop = GRID;
            cut  = 1'b1;
        end
        return stop;
    endfunction

    // Apply one request word to the tile tables and return its result
    function automatic tile_result_t track_word(input req_t kind,
                                                input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [COORD_W-1:0] w,
                                                input logic [COORD_W-1:0] h,
                                                input logic [TILE_W-1:0] col,
                                                input logic [TILE_W-1:0] row);
        tile_result_t      res;
        logic [HASH_W-1:0] rect_hash;
        logic              cut;
        int                c0, c1, r0, r1, cc, rr, idx;
        res = '0;
        cut = 1'b0;
        case (kind)
            REQ_FRAME:
            begin
                for (idx = 0; idx < NUM_TILES; idx++)
                    cur_hash[idx] = '0;
            end
            REQ_DAMAGE:
            begin
                rect_hash = 32'(x);
                rect_hash = rect_hash * HASH_MUL + 32'(y);
                rect_hash = rect_hash * HASH_MUL + 32'(w);
                rect_hash = rect_hash * HASH_MUL + 32'(h);
                c0 = int'(x) >> SHIFT;
                r0 = int'(y) >> SHIFT;
                c1 = span_stop(x, w, cut);
                r1 = span_stop(y, h, cut);
                for (rr = r0; rr < r1; rr++)
                    for (cc = c0; cc < c1; cc++)
                    begin
                        idx = rr * GRID + cc;
                        cur_hash[idx] = cur_hash[idx] * HASH_MUL + rect_hash;
                    end
                res.clipped = cut;
            end
            REQ_CHECK:
            begin
                if (int'(col) < GRID && int'(row) < GRID)
                begin
                    idx = int'(row) * GRID + int'(col);
                    res.is_dirty   = (cur_hash[idx] != prev_hash[idx]);
                    prev_hash[idx] = cur_hash[idx];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Predict on accepted input words, compare on accepted output words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tiles();
            result_fifo.delete();
            err_count   = 0;
            seen_count  = 0;
            dirty_count = 0;
            clip_count  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                result_fifo.push_back(track_word(req_t'(s_tuser),
                                                 s_tdata[11:0], s_tdata[23:12],
                                                 s_tdata[35:24], s_tdata[47:36],
                                                 s_tdata[52:48], s_tdata[57:53]));
            if (m_tvalid && m_tready)
            begin
                seen_count++;
                if (result_fifo.size() == 0)
                begin
                    $error("result word %h arrived with nothing expected", m_tdata);
                    err_count++;
                end
                else
                begin
                    want = result_fifo.pop_front();
                    dirty_count += want.is_dirty;
                    clip_count  += want.clipped;
                    if (m_tdata[OUT_DIRTY_BIT] !== want.is_dirty)
                    begin
                        $error("is_dirty mismatch: expected %0b, actual %0b",
                               want.is_dirty, m_tdata[OUT_DIRTY_BIT]);
                        err_count++;
                    end
                    if (m_tdata[OUT_CLIP_BIT] !== want.clipped)
                    begin
                        $error("clipped mismatch: expected %0b, actual %0b",
                               want.clipped, m_tdata[OUT_CLIP_BIT]);
                        err_count++;
                    end
                    if (m_tdata[M_DATA_W-1:2] !== '0)
                    begin
                        $error("padding mismatch: expected %0h, actual %0h",
                               0, m_tdata[M_DATA_W-1:2]);
                        err_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/tile_damage_hash_tracker_core_tb.sv -----
// ============================================================================
// tile_damage_hash_tracker_core_tb
// Stimulus and verdict for the tile damage hash tracker: directed corner
// words, a long stall of the result side, then frame-shaped random traffic
// (clear, a few damage rectangles, checks near the damage) with random gaps.
// ============================================================================
module tile_damage_hash_tracker_core_tb;
    import tdht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 400;
    localparam int QUIET_FROM   = 340;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_LIMIT  = 20000;

    logic                clk;
    logic                rst_n;
    logic [REQ_W-1:0]    s_tuser;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;

    int mismatches, pending, results_seen, dirty_seen, clipped_seen;

    // Sender-side bookkeeping
    int n_frame, n_damage, n_check, n_unused, n_random;
    bit quiet;
    bit calm;
    bit hold_req;
    bit hold_done;

    tile_damage_hash_tracker_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    tdht_result_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .dirty_seen   (dirty_seen),
        .clipped_seen (clipped_seen)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one request word and hold it until taken, then maybe idle
    task automatic send_word(input req_t kind,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                             input logic [TILE_W-1:0] col, input logic [TILE_W-1:0] row);
        s_tuser  <= kind;
        s_tdata  <= {6'd0, row, col, h, w, y, x};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        case (kind)
            REQ_FRAME:  n_frame++;
            REQ_DAMAGE: n_damage++;
            REQ_CHECK:  n_check++;
            default:    n_unused++;
        endcase
        if (!quiet && !calm && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 60)) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [COORD_W-1:0] rx, ry, rw, rh;
        int                 k, n_dmg, n_chk, tc, tr, waited;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        quiet    = 1'b0;
        calm     = 1'b0;
        hold_req = 1'b0;
        rx = '0;
        ry = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd0,  5'd0);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd0,  5'd0);
        // zero-size rect on a tile boundary covers no tile: tile stays clean
        send_word(REQ_DAMAGE, 12'd0,    12'd0,    12'd0,    12'd0,    5'd0,  5'd0);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd0,  5'd0);
        send_word(REQ_DAMAGE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 5'd31, 5'd31);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd31, 5'd31);
        // spans ending exactly on the grid edge, then one pixel past it
        send_word(REQ_DAMAGE, 12'd0,    12'd0,    12'd4095, 12'd4095, 5'd0,  5'd0);
        send_word(REQ_DAMAGE, 12'd1,    12'd0,    12'd4095, 12'd10,   5'd0,  5'd0);
        send_word(REQ_DAMAGE, 12'd2,    12'd0,    12'd4095, 12'd10,   5'd0,  5'd0);
        send_word(REQ_DAMAGE, 12'd0,    12'd2,    12'd10,   12'd4095, 5'd0,  5'd0);
        send_word(REQ_DAMAGE, 12'd3968, 12'd0,    12'd127,  12'd0,    5'd0,  5'd0);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd31, 5'd0);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd0,  5'd31);
        send_word(REQ_NONE,   12'd4095, 12'd4095, 12'd4095, 12'd4095, 5'd31, 5'd31);
        send_word(REQ_FRAME,  12'd4095, 12'd4095, 12'd4095, 12'd4095, 5'd31, 5'd31);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd0,  5'd0);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd31, 5'd31);
        // rect straddling a tile corner
        send_word(REQ_DAMAGE, 12'd127,  12'd127,  12'd2,    12'd2,    5'd0,  5'd0);
        send_word(REQ_DAMAGE, 12'd127,  12'd127,  12'd2,    12'd2,    5'd0,  5'd0);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd1,  5'd1);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd1,  5'd1);
        send_word(REQ_FRAME,  12'd0,    12'd0,    12'd0,    12'd0,    5'd0,  5'd0);
        send_word(REQ_CHECK,  12'd0,    12'd0,    12'd0,    12'd0,    5'd1,  5'd1);

        // Back-pressure: result side holds off while checks keep coming
        calm     = 1'b1;
        hold_req = 1'b1;
        for (k = 0; k < 24; k++)
            send_word(REQ_CHECK, 12'($urandom), 12'($urandom), 12'($urandom),
                      12'($urandom), 5'($urandom), 5'($urandom));

        // Random frames: clear, damage, checks near the damage, some noise
        n_random = 0;
        while (n_random < RANDOM_WORDS)
        begin
            quiet = (n_random >= QUIET_FROM);
            calm  = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                send_word(REQ_FRAME, 12'($urandom), 12'($urandom), 12'($urandom),
                          12'($urandom), 5'($urandom), 5'($urandom));
                n_random++;
            end
            n_dmg = $urandom_range(1, 4);
            for (k = 0; k < n_dmg; k++)
            begin
                rx = 12'($urandom);
                ry = 12'($urandom);
                if ($urandom_range(0, 9) == 0)
                begin
                    rw = 12'($urandom);
                    rh = 12'($urandom);
                end
                else
                begin
                    rw = 12'($urandom_range(0, 400));
                    rh = 12'($urandom_range(0, 400));
                end
                send_word(REQ_DAMAGE, rx, ry, rw, rh, 5'($urandom), 5'($urandom));
                n_random++;
            end
            n_chk = $urandom_range(2, 6);
            for (k = 0; k < n_chk; k++)
            begin
                // mostly tiles at or just past the last rectangle's corner
                if ($urandom_range(0, 3) != 0)
                begin
                    tc = (int'(rx) >> TILE_SHIFT_DEF) + $urandom_range(0, 2);
                    tr = (int'(ry) >> TILE_SHIFT_DEF) + $urandom_range(0, 2);
                    if (tc > GRID_TILES_DEF - 1) tc = GRID_TILES_DEF - 1;
                    if (tr > GRID_TILES_DEF - 1) tr = GRID_TILES_DEF - 1;
                end
                else
                begin
                    tc = $urandom_range(0, GRID_TILES_DEF - 1);
                    tr = $urandom_range(0, GRID_TILES_DEF - 1);
                end
                send_word(REQ_CHECK, 12'($urandom), 12'($urandom), 12'($urandom),
                          12'($urandom), 5'(tc), 5'(tr));
                n_random++;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                send_word(REQ_NONE, 12'($urandom), 12'($urandom), 12'($urandom),
                          12'($urandom), 5'($urandom), 5'($urandom));
                n_random++;
            end
        end

        // Drain
        @(posedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        if (pending != 0)
            $error("%0d expected result words never arrived", pending);

        $display("Covered %0d frame clears, %0d damage rects, %0d tile checks, %0d unused codes",
                 n_frame, n_damage, n_check, n_unused);
        $display("Compared %0d result words: %0d dirty tiles, %0d clipped rects",
                 results_seen, dirty_seen, clipped_seen);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tdht_pkg.sv
rtl/tdht_ram.sv
rtl/tile_damage_hash_tracker_core.sv
rtl/tdht_checker.sv
tb/tdht_result_checker.sv
tb/tile_damage_hash_tracker_core_tb.sv
